// ----- rtl/word_line_splitter_macros.svh -----
// ----------------------------------------------------------------------------
// word line splitter assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef WORD_LINE_SPLITTER_MACROS_SVH
`define WORD_LINE_SPLITTER_MACROS_SVH

// same-cycle implication
`define WLS_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wls_pkg.sv -----
// ----------------------------------------------------------------------------
// wls_pkg
// constants and result type of the word line splitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wls_pkg;

    localparam int POS_W   = 21;
    localparam int START_W = 20;
    localparam int LEN_W   = 8;
    localparam int TRIM_W  = 9;
    localparam int TALLY_W = 21;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [TRIM_W-1:0]  NONE_SEEN      = '1;
    localparam logic [TRIM_W-1:0]  MAX_WORD_CHARS = 9'd32;
    localparam logic [POS_W-1:0]   BUFFER_BYTES   = 21'd1048576;

    typedef struct packed {
        logic                 has_word;
        logic [START_W-1:0]   word_start;
        logic [LEN_W-1:0]     word_length;
        logic [TALLY_W-1:0]   total_words;
        logic                 end_of_list;
    } wls_result_t;

endpackage

// ----- rtl/word_line_splitter.sv -----
// a result is registered in the output slot (or the skid slot while the output slot waits) before m_tvalid shows it
// throughput: one byte per cycle while s_tready is high; line state updates in a single compare-and-count step
// a two-deep result register (output plus skid) keeps s_tready high while a result waits
// s_tready drops only when both result slots are full
// rst_n (async, active low) clears line state, position, word count and both result slots
// ----------------------------------------------------------------------------
// word_line_splitter
// splits a streamed word list into trimmed lines, reports start and length of each word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "word_line_splitter_macros.svh"

module word_line_splitter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [19:0] word_start, [27:20] word_length,
                                   // [48:28] total_words, [55:49] zero
    output logic        m_tlast,   // end_of_list
    output logic        m_tuser    // has_word
);

    logic                 in_fire, out_fire, core_valid;
    wls_pkg::wls_result_t core_res;
    wls_pkg::wls_result_t out_reg, skid_reg;
    logic                 out_valid_reg, skid_valid_reg;

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;

    wls_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_fire),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .res_valid  (core_valid),
        .res        (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= core_valid;
        end
        else if (core_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
            out_reg <= skid_valid_reg ? skid_reg : core_res;
        else if (core_valid)
            skid_reg <= core_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.total_words, out_reg.word_length, out_reg.word_start};
    assign m_tlast  = out_reg.end_of_list;
    assign m_tuser  = out_reg.has_word;

    `WLS_ASSERT_HOLDS(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid slot full while output slot empty")

    `WLS_ASSERT_HOLDS(a_empty_word_zero, m_tvalid && !m_tuser, m_tdata[27:0] == 28'd0,
        "non-word result carries start or length")

    `WLS_ASSERT_HOLDS(a_word_len_range, m_tvalid && m_tuser,
        (m_tdata[27:20] != 8'd0) && ({1'b0, m_tdata[27:20]} <= wls_pkg::MAX_WORD_CHARS),
        "word length outside limit")

    `WLS_ASSERT_NEXT(a_no_phantom, !out_valid_reg && !core_valid, !out_valid_reg,
        "result appeared without a source")

endmodule

// ----- rtl/wls_core.sv -----
// ----------------------------------------------------------------------------
// wls_core
// per-byte line tracking, trim and word acceptance, one byte per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wls_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [7:0]           data_byte,
    input  logic                 final_byte,
    output logic                 res_valid,
    output wls_pkg::wls_result_t res
);

    logic                              in_line_reg, in_line_next;
    logic [wls_pkg::START_W-1:0]       start_reg, start_next;
    logic [wls_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [wls_pkg::TRIM_W-1:0]        loff_reg, loff_next;
    logic [wls_pkg::TRIM_W-1:0]        trim_reg, trim_next;
    logic [wls_pkg::TRIM_W-1:0]        unpr_reg, unpr_next;
    logic [wls_pkg::TALLY_W-1:0]       tally_reg, tally_next;

    logic                              pos_ok, is_nl, is_blank, is_print;
    logic                              opening, content, nl_close, open_after, closing, ok;
    logic [wls_pkg::TRIM_W-1:0]        off, trim_a, unpr_a, trim_base, unpr_base;
    logic [wls_pkg::START_W-1:0]       start_a;

    always_comb
    begin
        pos_ok   = pos_reg < wls_pkg::BUFFER_BYTES;
        is_nl    = (data_byte == wls_pkg::CH_LF) || (data_byte == wls_pkg::CH_CR);
        is_blank = (data_byte == wls_pkg::CH_SPACE) || (data_byte == wls_pkg::CH_TAB);
        is_print = (data_byte >= wls_pkg::CH_SPACE) && (data_byte < wls_pkg::CH_DEL);

        opening  = pos_ok && !in_line_reg && !is_nl && !is_blank;
        content  = pos_ok && in_line_reg && !is_nl;
        nl_close = pos_ok && in_line_reg && is_nl;

        // offset of this byte inside its line, saturated
        off       = opening ? '0 : loff_reg;
        trim_base = opening ? '0 : trim_reg;
        unpr_base = opening ? wls_pkg::NONE_SEEN : unpr_reg;

        trim_a = trim_reg;
        unpr_a = unpr_reg;
        if (opening || content)
        begin
            trim_a = trim_base;
            unpr_a = unpr_base;
            if (!is_blank)
                trim_a = (off == wls_pkg::NONE_SEEN) ? wls_pkg::NONE_SEEN : off + 9'd1;
            if (!is_print && unpr_base == wls_pkg::NONE_SEEN && off != wls_pkg::NONE_SEEN)
                unpr_a = off;
        end
        start_a = opening ? pos_reg[wls_pkg::START_W-1:0] : start_reg;

        open_after = opening || content || (in_line_reg && !pos_ok);
        closing    = nl_close || (final_byte && open_after);
        ok         = closing && (trim_a != '0) && (trim_a <= wls_pkg::MAX_WORD_CHARS)
                     && !(unpr_a < trim_a);

        tally_next = tally_reg;
        if (ok && tally_reg < wls_pkg::BUFFER_BYTES)
            tally_next = tally_reg + 21'd1;

        res_valid       = in_valid && (ok || final_byte);
        res.has_word    = ok;
        res.word_start  = ok ? start_a : '0;
        res.word_length = ok ? trim_a[wls_pkg::LEN_W-1:0] : '0;
        res.total_words = tally_next;
        res.end_of_list = final_byte;

        in_line_next = open_after && !nl_close;
        start_next   = start_a;
        pos_next     = pos_ok ? pos_reg + 21'd1 : pos_reg;
        if (opening)
            loff_next = 9'd1;
        else if (content)
            loff_next = (loff_reg == wls_pkg::NONE_SEEN) ? loff_reg : loff_reg + 9'd1;
        else
            loff_next = loff_reg;
        trim_next = closing ? '0 : trim_a;
        unpr_next = closing ? wls_pkg::NONE_SEEN : unpr_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_line_reg <= 1'b0;
            start_reg   <= '0;
            pos_reg     <= '0;
            loff_reg    <= '0;
            trim_reg    <= '0;
            unpr_reg    <= wls_pkg::NONE_SEEN;
            tally_reg   <= '0;
        end
        else if (in_valid)
        begin
            if (final_byte)
            begin
                // list done, back to reset state
                in_line_reg <= 1'b0;
                start_reg   <= '0;
                pos_reg     <= '0;
                loff_reg    <= '0;
                trim_reg    <= '0;
                unpr_reg    <= wls_pkg::NONE_SEEN;
                tally_reg   <= '0;
            end
            else
            begin
                in_line_reg <= in_line_next;
                start_reg   <= start_next;
                pos_reg     <= pos_next;
                loff_reg    <= loff_next;
                trim_reg    <= trim_next;
                unpr_reg    <= unpr_next;
                tally_reg   <= tally_next;
            end
        end
    end

endmodule

// ----- tb/word_line_splitter_test.sv -----
// ----------------------------------------------------------------------------
// word_line_splitter_test
// streams word lists into the splitter byte by byte, predicts every
// result (word or end of list) in a local model and checks each one in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_line_splitter_test;

    import wls_pkg::*;

    localparam int unsigned TARGET_BYTES = 1850;
    localparam int unsigned STUCK_LIMIT  = 2000;
    localparam int unsigned LONG_HOLD    = 320;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;   // wait for all results before offering this byte
    } text_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic        s_tlast = 1'b0;    // final_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // [19:0] word_start, [27:20] word_length,
                                    // [48:28] total_words, [55:49] zero
    logic        m_tlast;           // end_of_list
    logic        m_tuser;           // has_word

    text_byte_t  text_queue[$];
    wls_result_t expected_words[$];

    // line tracking state of the predictor
    logic                in_line = 1'b0;
    logic [START_W-1:0]  line_origin = '0;
    logic [POS_W-1:0]    byte_pos = '0;
    logic [TRIM_W-1:0]   trim_len = '0;
    logic [TRIM_W-1:0]   first_bad = NONE_SEEN;
    logic [TALLY_W-1:0]  tally_model = '0;

    int unsigned error_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_checked = 0;
    int unsigned words_found = 0;
    int unsigned lists_closed = 0;
    int unsigned stuck_cycles = 0;
    int unsigned tx_gap = 0;
    int unsigned tx_calm = 0;
    int unsigned rx_stall = 0;
    int unsigned rx_calm = 0;
    int unsigned rx_count = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    word_line_splitter dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mostly short gaps, a few long ones, and calm stretches with none
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0)
        begin
            calm = calm - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic bit is_separator(input logic [7:0] b);
        return b == CH_LF || b == CH_CR || b == CH_SPACE || b == CH_TAB;
    endfunction

    function automatic void clear_line_state();
        in_line = 1'b0;
        trim_len = '0;
        first_bad = NONE_SEEN;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b, input int unsigned pos);
        int unsigned off;
        off = pos - line_origin;
        if (b != CH_SPACE && b != CH_TAB)
            trim_len = (off + 1 > 511) ? 9'd511 : TRIM_W'(off + 1);
        if ((b < CH_SPACE || b >= CH_DEL) && first_bad == NONE_SEEN && off < 511)
            first_bad = TRIM_W'(off);
    endfunction

    function automatic bit close_word(output logic [START_W-1:0] ws, output logic [LEN_W-1:0] wl);
        bit ok;
        ws = '0;
        wl = '0;
        ok = trim_len >= 1 && trim_len <= MAX_WORD_CHARS && !(first_bad < trim_len);
        if (ok)
        begin
            ws = line_origin;
            wl = trim_len[LEN_W-1:0];
            if (tally_model < BUFFER_BYTES)
                tally_model = tally_model + 1'b1;
        end
        clear_line_state();
        return ok;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic fin);
        int unsigned        pos;
        bit                 got;
        logic [START_W-1:0] ws;
        logic [LEN_W-1:0]   wl;
        wls_result_t        r;
        got = 1'b0;
        ws = '0;
        wl = '0;
        if (byte_pos < BUFFER_BYTES)
        begin
            pos = byte_pos;
            byte_pos = byte_pos + 1'b1;
            if (!in_line)
            begin
                if (!is_separator(b))
                begin
                    in_line = 1'b1;
                    line_origin = START_W'(pos);
                    trim_len = '0;
                    first_bad = NONE_SEEN;
                    absorb_byte(b, pos);
                end
            end
            else if (b == CH_LF || b == CH_CR)
                got = close_word(ws, wl);
            else
                absorb_byte(b, pos);
        end
        // a final byte closes an open line as if a line feed followed
        if (fin && in_line)
            got = close_word(ws, wl);
        if (got || fin)
        begin
            r.has_word = got;
            r.word_start = ws;
            r.word_length = wl;
            r.total_words = tally_model;
            r.end_of_list = fin;
            expected_words.push_back(r);
        end
        if (fin)
        begin
            clear_line_state();
            line_origin = '0;
            byte_pos = '0;
            tally_model = '0;
        end
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic fin);
        text_byte_t t;
        t.data = b;
        t.last = fin;
        t.drain = 1'b0;
        text_queue.push_back(t);
    endtask

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    // one list of lines; noisy lists are raw random bytes
    task automatic build_list(input bit noisy, input bit long_line, input bit drain_first);
        logic [7:0]  text[$];
        logic [7:0]  c;
        text_byte_t  t;
        int unsigned n_lines, len, r;
        if (noisy)
        begin
            repeat ($urandom_range(1, 40))
                text.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            n_lines = $urandom_range(1, 12);
            for (int ln = 0; ln < n_lines; ln++)
            begin
                repeat ($urandom_range(0, 2))
                    text.push_back(pick_separator());
                r = $urandom_range(0, 99);
                if (long_line && ln == 0)
                    len = $urandom_range(515, 530);
                else if (r < 5)
                    len = 0;
                else if (r < 85)
                    len = $urandom_range(1, 34);
                else
                    len = $urandom_range(35, 60);
                for (int i = 0; i < len; i++)
                begin
                    c = 8'($urandom_range(8'h21, 8'h7E));
                    if (i > 0 && i + 1 < len && $urandom_range(0, 9) == 0)
                        c = pick_blank();
                    if ($urandom_range(0, 199) == 0)
                        c = 8'($urandom_range(0, 255));
                    text.push_back(c);
                end
                repeat ($urandom_range(0, 3))
                    text.push_back(pick_blank());
                if (!(ln + 1 == n_lines && $urandom_range(0, 1) == 0))
                begin
                    r = $urandom_range(0, 9);
                    if (r < 5)
                        text.push_back(CH_LF);
                    else if (r < 8)
                        text.push_back(CH_CR);
                    else
                    begin
                        text.push_back(CH_CR);
                        text.push_back(CH_LF);
                    end
                end
            end
            if (text.size() == 0)
                text.push_back(CH_LF);
        end
        foreach (text[i])
        begin
            t.data = text[i];
            t.last = (i == text.size() - 1);
            t.drain = drain_first && i == 0;
            text_queue.push_back(t);
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // sender: offers queued bytes, predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tlast <= 1'b0;
            tx_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_byte(s_tdata, s_tlast);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end
                else if (text_queue.size() != 0 &&
                         (!text_queue[0].drain || expected_words.size() == 0))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= text_queue[0].data;
                    s_tlast <= text_queue[0].last;
                    void'(text_queue.pop_front());
                    tx_gap <= pick_gap(tx_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold once results are flowing
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall <= 0;
            rx_count <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                rx_count <= rx_count + 1;
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && rx_count >= 40)
            begin
                m_tready <= 1'b0;
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
            end
            else if (rx_stall != 0)
            begin
                m_tready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end
            else
            begin
                int unsigned g;
                g = pick_gap(rx_calm);
                if (g == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    rx_stall <= g - 1;
                end
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            wls_result_t w;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual data %0h last %0b user %0b",
                         $time, m_tdata, m_tlast, m_tuser);
                error_count++;
            end
            else
            begin
                w = expected_words.pop_front();
                report_field("has_word", 32'(w.has_word), 32'(m_tuser));
                report_field("word_start", 32'(w.word_start), 32'(m_tdata[19:0]));
                report_field("word_length", 32'(w.word_length), 32'(m_tdata[27:20]));
                report_field("total_words", 32'(w.total_words), 32'(m_tdata[48:28]));
                report_field("end_of_list", 32'(w.end_of_list), 32'(m_tlast));
                report_field("tdata padding", 32'(0), 32'(m_tdata[55:49]));
                results_checked++;
                if (w.has_word)
                    words_found++;
                if (w.end_of_list)
                    lists_closed++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, stuck_cycles, expected_words.size());
                $display("word_line_splitter verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned list_idx;

        // blanks and separators before a word, trailing blanks trimmed, CR end
        push_byte(CH_SPACE, 1'b0);
        push_byte(CH_TAB, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte("a", 1'b0);
        push_byte("b", 1'b0);
        push_byte(CH_SPACE, 1'b0);
        push_byte(CH_TAB, 1'b0);
        push_byte(CH_CR, 1'b0);
        // printable edges with an inner space
        push_byte(8'h7E, 1'b0);
        push_byte(CH_SPACE, 1'b0);
        push_byte("!", 1'b0);
        push_byte(CH_LF, 1'b0);
        // delete and out-of-range bytes reject the line
        push_byte("q", 1'b0);
        push_byte(CH_DEL, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(CH_CR, 1'b0);
        // final byte inside a word closes it
        push_byte("z", 1'b1);
        // list of just a final separator: end with no word
        push_byte(CH_LF, 1'b1);
        // final byte is the line feed ending a word
        push_byte("m", 1'b0);
        push_byte(CH_LF, 1'b1);
        // one-byte list holding a word
        push_byte("k", 1'b1);

        list_idx = 0;
        while (text_queue.size() < TARGET_BYTES)
        begin
            build_list($urandom_range(0, 9) == 0, list_idx == 8,
                       list_idx == 15 || list_idx == 70);
            list_idx++;
        end

        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (text_queue.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("run covered %0d bytes in %0d lists, %0d results checked, %0d words accepted",
                 bytes_sent, lists_closed, results_checked, words_found);
        if (error_count == 0)
            $display("word_line_splitter verification clean");
        else
            $display("word_line_splitter verification failed");
        $finish;
    end

endmodule
